>>> rtl/core/dsf_pkg.sv
// shared types, constants and the sine table builder for the dsf oscillator
`default_nettype none
package dsf_pkg;

	localparam int DIVIDE_STEPS = 16;
	localparam int ACC_W        = 56;
	localparam int DSH_W        = 47;
	localparam int WFAC_W       = 15;
	localparam logic [22:0] Q23_MAX = 23'h7fffff;
	localparam logic [23:0] RATIO_BASE = 24'd8279556;
	localparam logic [14:0] WFAC_BASE = 15'd16384;
	localparam logic [6:0] WFAC_STEP = 7'h5a;
	localparam logic [6:0] DIAL_FULL = 7'd127;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// payload handed from one divide cell to the next
	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		logic              carry;
		logic [DSH_W-1:0]  dsh;
		logic              num_neg;
		logic [WFAC_W-1:0] wfac;
	} div_beat_t;

	// next taylor term before its factorial step: term * x^2 in q30, used at elaboration only
	function automatic longint unsigned taylor_mul(input longint unsigned term,
			input longint unsigned x);
		longint unsigned t;
		t = (term * x) >> 30;
		t = (t * x) >> 30;
		return t;
	endfunction

	// clamp the q30 sum at zero, round to q23 and cap, used at elaboration only
	function automatic logic [22:0] sine_round(input longint sum);
		longint v;
		v = (sum < 0) ? 64'sd0 : sum;
		v = (v + 64'sd64) >>> 7;
		if (v > 64'sd8388607) begin
			v = 64'sd8388607;
		end
		return v[22:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/dsf_rom.sv
// quarter-wave q23 sine rom with registered read
`default_nettype none
module dsf_rom
	import dsf_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [$clog2(DEPTH+1)-1:0] addr,
	output logic      [22:0]                data_q
);

	logic [22:0] rom_tbl [DEPTH+1];

	// q30 taylor series of sin(pi/2 * k / depth) to x^15, each term floored
	for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
		localparam longint unsigned X  = (HALF_PI_Q30 * k) / DEPTH;
		localparam longint unsigned T1 = taylor_mul(X, X) / 6;
		localparam longint unsigned T2 = taylor_mul(T1, X) / 20;
		localparam longint unsigned T3 = taylor_mul(T2, X) / 42;
		localparam longint unsigned T4 = taylor_mul(T3, X) / 72;
		localparam longint unsigned T5 = taylor_mul(T4, X) / 110;
		localparam longint unsigned T6 = taylor_mul(T5, X) / 156;
		localparam longint unsigned T7 = taylor_mul(T6, X) / 210;
		localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
			+ longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7);
		localparam logic [22:0] VAL = sine_round(SUM);
		assign rom_tbl[k] = VAL;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= rom_tbl[addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/dsf_div_cell.sv
// one non-restoring divide step with its pipeline register
`default_nettype none
module dsf_div_cell
	import dsf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      vld_in,
	input  wire div_beat_t beat_in,
	output logic           vld_q,
	output div_beat_t      beat_q
);

	logic [ACC_W-1:0] shifted;
	logic [ACC_W-1:0] acc_next;
	logic [ACC_W-1:0] dsh_ext;

	always_comb begin
		shifted  = {beat_in.acc[ACC_W-2:0], beat_in.carry};
		dsh_ext  = {{(ACC_W-DSH_W){1'b0}}, beat_in.dsh};
		acc_next = beat_in.acc[ACC_W-1] ? shifted + dsh_ext : shifted - dsh_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q.acc     <= acc_next;
			beat_q.carry   <= ~acc_next[ACC_W-1];
			beat_q.dsh     <= beat_in.dsh;
			beat_q.num_neg <= beat_in.num_neg;
			beat_q.wfac    <= beat_in.wfac;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/dsf_oscillator_with_dsp_divide.sv
// dsf oscillator top level: rom lookup, denominator and a 16-cell divide chain
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------
//  src      | src_valid/src_stall | mode, phase, pitch_increment
//  res      | res_valid/res_stall | sample
//  cfg      | cfg_valid/cfg_ready | cfg_data (shape dial)
//
// one beat accepted per cycle while res_stall does not hold the pipe
// pipeline: input regs, rom read, products, denominator, 16 divide cells,
// quotient scaling, output register
// arst_n clears valid bits and the shape dial
// res_stall with a waiting result freezes the whole pipe and raises src_stall
`default_nettype none
module dsf_oscillator_with_dsp_divide
	import dsf_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_BITS       = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  src_valid,
	output logic                       src_stall,
	input  wire logic                  mode,
	input  wire logic [PHASE_BITS-1:0] phase,
	input  wire logic [22:0]           pitch_increment,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic signed [25:0]         sample,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [6:0]            cfg_data
);

	localparam int D  = SINE_TABLE_DEPTH;
	localparam int IW = $clog2(4 * D);
	localparam int AW = $clog2(D + 1);
	localparam int JW = IW + 3;
	localparam logic [JW-1:0] D_J    = JW'(D);
	localparam logic [JW-1:0] D2_J   = JW'(2 * D);
	localparam logic [JW-1:0] D3_J   = JW'(3 * D);
	localparam logic [JW-1:0] D4_J   = JW'(4 * D);
	localparam logic [IW:0]   D4_MUL = (IW + 1)'(4 * D);

	typedef struct packed {
		logic [AW-1:0] addr;
		logic          neg;
	} rom_sel_t;

	// fold a full-cycle index (below 4 depth) to a quarter-wave address and sign
	function automatic rom_sel_t fold_index(input logic [JW-1:0] ix);
		rom_sel_t r;
		logic [JW-1:0] t;
		if (ix < D_J) begin
			t = ix;
			r.neg = 1'b0;
		end else if (ix < D2_J) begin
			t = D2_J - ix;
			r.neg = 1'b0;
		end else if (ix < D3_J) begin
			t = ix - D2_J;
			r.neg = 1'b1;
		end else begin
			t = D4_J - ix;
			r.neg = 1'b1;
		end
		r.addr = t[AW-1:0];
		return r;
	endfunction

	logic adv;
	logic [6:0] shape_dial_q;

	// config register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_dial_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			shape_dial_q <= cfg_data;
		end
	end

	// pipe moves unless a finished result is held back
	assign adv       = !(res_valid && res_stall);
	assign src_stall = !adv;

	// stage 1: index, ratio factor, shape word
	logic [PHASE_BITS+IW:0] ph_prod;
	logic [IW-1:0]          idx;
	logic [JW-1:0]          jc;
	logic [JW-1:0]          jc_r;
	logic signed [27:0]     fac_raw;
	logic [7:0]             w_word;
	rom_sel_t               sin_sel;
	rom_sel_t               cos_sel;

	always_comb begin
		ph_prod = (PHASE_BITS + IW + 1)'(phase) * (PHASE_BITS + IW + 1)'(D4_MUL);
		idx     = ph_prod[PHASE_BITS+IW-1:PHASE_BITS];
		jc      = mode ? ({2'b00, idx, 1'b0} + D_J) : ({3'b000, idx} + D_J);
		jc_r    = jc;
		if (jc_r >= D4_J) begin
			jc_r = jc_r - D4_J;
		end
		if (jc_r >= D4_J) begin
			jc_r = jc_r - D4_J;
		end
		sin_sel = fold_index({3'b000, idx});
		cos_sel = fold_index(jc_r);
		fac_raw = signed'({4'b0000, RATIO_BASE}) - signed'({2'b00, pitch_increment, 3'b000});
		w_word  = (shape_dial_q >= DIAL_FULL) ? 8'd128 : {1'b0, shape_dial_q};
	end

	logic              v_s1;
	rom_sel_t          sin_s1, cos_s1;
	logic [22:0]       fac_s1;
	logic [7:0]        w_s1;
	logic [WFAC_W-1:0] wfac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_s1  <= sin_sel;
			cos_s1  <= cos_sel;
			fac_s1  <= fac_raw[27] ? 23'd0 : fac_raw[22:0];
			w_s1    <= w_word;
			wfac_s1 <= WFAC_BASE - (WFAC_W'(w_word) * WFAC_W'(WFAC_STEP));
		end
	end

	// stage 2: rom reads and ratio in q30
	logic [22:0]       sin_rom, cos_rom;
	logic              v_s2;
	logic              sin_neg_s2, cos_neg_s2;
	logic [30:0]       ratio_s2;
	logic [WFAC_W-1:0] wfac_s2;

	dsf_rom #(.DEPTH(D)) u_sin_rom (
		.clk(clk), .en(adv), .addr(sin_s1.addr), .data_q(sin_rom)
	);

	dsf_rom #(.DEPTH(D)) u_cos_rom (
		.clk(clk), .en(adv), .addr(cos_s1.addr), .data_q(cos_rom)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sin_neg_s2 <= sin_s1.neg;
			cos_neg_s2 <= cos_s1.neg;
			ratio_s2   <= 31'(w_s1) * 31'(fac_s1);
			wfac_s2    <= wfac_s1;
		end
	end

	// stage 3: r*c and r*r products, numerator
	logic signed [23:0] sin_val, cos_val;
	logic signed [55:0] rc_s3;
	logic [61:0]        rr_s3;
	logic signed [19:0] num_s3;
	logic               v_s3;
	logic [WFAC_W-1:0]  wfac_s3;

	always_comb begin
		sin_val = sin_neg_s2 ? -signed'({1'b0, sin_rom}) : signed'({1'b0, sin_rom});
		cos_val = cos_neg_s2 ? -signed'({1'b0, cos_rom}) : signed'({1'b0, cos_rom});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rc_s3   <= signed'({1'b0, ratio_s2}) * 56'(cos_val);
			rr_s3   <= 62'(ratio_s2) * 62'(ratio_s2);
			num_s3  <= 20'(sin_val >>> 4);
			wfac_s3 <= wfac_s2;
		end
	end

	// stage 4: denominator (1 - 2rc + r^2)/4 in q23, floored and capped
	logic signed [65:0] d60;
	logic [26:0]        den_wide;
	logic [22:0]        den_s4;
	logic signed [19:0] num_s4;
	logic               v_s4;
	logic [WFAC_W-1:0]  wfac_s4;

	always_comb begin
		d60 = (66'sd1 <<< 60) - (66'(rc_s3) <<< 8) + signed'({4'b0000, rr_s3});
		den_wide = d60[65] ? 27'd0 : d60[65:39];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s4  <= (den_wide > 27'(Q23_MAX)) ? Q23_MAX : den_wide[22:0];
			num_s4  <= num_s3;
			wfac_s4 <= wfac_s3;
		end
	end

	// divide chain: one non-restoring step per cell
	div_beat_t         beat_in0;
	div_beat_t         beat_c [DIVIDE_STEPS];
	logic              vld_c  [DIVIDE_STEPS];
	logic [19:0]       num_mag;

	always_comb begin
		num_mag          = num_s4[19] ? 20'(-num_s4) : 20'(num_s4);
		beat_in0.acc     = {12'd0, num_mag, 24'd0};
		beat_in0.carry   = 1'b0;
		beat_in0.dsh     = {den_s4, 24'd0};
		beat_in0.num_neg = num_s4[19];
		beat_in0.wfac    = wfac_s4;
	end

	for (genvar i = 0; i < DIVIDE_STEPS; i++) begin : g_cell
		if (i == 0) begin : g_first
			dsf_div_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.vld_in(v_s4), .beat_in(beat_in0),
				.vld_q(vld_c[i]), .beat_q(beat_c[i])
			);
		end else begin : g_next
			dsf_div_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.vld_in(vld_c[i-1]), .beat_in(beat_c[i-1]),
				.vld_q(vld_c[i]), .beat_q(beat_c[i])
			);
		end
	end

	// stage 5: sign restore, q23 quotient word, level scaling product
	logic [ACC_W-1:0]   acc_fix;
	logic signed [23:0] quot;
	logic signed [39:0] prod_s5;
	logic               v_s5;
	div_beat_t          last_beat;

	always_comb begin
		last_beat = beat_c[DIVIDE_STEPS-1];
		acc_fix   = last_beat.num_neg ? (ACC_W'(0) - last_beat.acc) : last_beat.acc;
		// shift by 32 and the 24-bit window leave the low 16 accumulator bits on top
		quot      = signed'({acc_fix[15:0], 8'h00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= vld_c[DIVIDE_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5 <= 40'(quot) * signed'({25'd0, last_beat.wfac});
		end
	end

	// output register, floor divide by 4096
	logic signed [39:0] prod_shr;
	assign prod_shr = prod_s5 >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample <= prod_shr[25:0];
		end
	end

	// an accepted beat shows up in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> v_s1)
		else $error("accepted beat missing from stage 1");

	// a held result freezes the end of the divide chain
	a_hold_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(vld_c[DIVIDE_STEPS-1]) && $stable(v_s5))
		else $error("divide chain moved under stall");

	// scaling factor stays within its range for every shape word
	a_wfac_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (wfac_s1 >= 15'd4864) && (wfac_s1 <= WFAC_BASE))
		else $error("shape scaling out of range");

endmodule
`default_nettype wire

>>> dv/tb.sv
// self-checking testbench for the dsf oscillator with dsp divide
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import dsf_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int PBITS      = 24;
	localparam int PIPE_DEPTH = 22;
	localparam int CYCLE_CAP  = 400000;
	localparam int N_RANDOM   = 1800;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_stall;
	logic                mode = 1'b0;
	logic [PBITS-1:0]    phase = '0;
	logic [22:0]         pitch_increment = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	logic signed [25:0]  sample;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [6:0]          cfg_data = '0;

	// directed row: a stimulus beat plus the dial to use
	typedef struct {
		logic [6:0]       dial;
		logic             md;
		logic [PBITS-1:0] ph;
		logic [22:0]      inc;
	} vec_row_t;

	int                 rom_q23 [0:DEPTH];
	logic signed [25:0] sample_q [$];
	logic [6:0]         dial_now = '0;
	int                 mismatches = 0;
	int                 cycles = 0;
	bit                 quiet = 1'b0;

	always #1 clk = ~clk;

	dsf_oscillator_with_dsp_divide DUT (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall),
		.mode(mode), .phase(phase), .pitch_increment(pitch_increment),
		.res_valid(res_valid), .res_stall(res_stall), .sample(sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// quarter-wave table, q30 taylor series rounded to q23
	function automatic int taylor_q23(input int k);
		longint unsigned x, term;
		longint s, v;
		x = (64'd1686629713 * longint'(k)) / DEPTH;
		term = x;
		s = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) s = s - longint'(term);
			else s = s + longint'(term);
		end
		if (s < 0) s = 0;
		v = (s + 64) >>> 7;
		if (v > 8388607) v = 8388607;
		return int'(v);
	endfunction

	function automatic longint wave_at(input longint unsigned i);
		longint unsigned quad, r;
		i = i % (4 * DEPTH);
		quad = i / DEPTH;
		r = i % DEPTH;
		case (quad)
			0: return rom_q23[r];
			1: return rom_q23[DEPTH - r];
			2: return -rom_q23[r];
			default: return -rom_q23[DEPTH - r];
		endcase
	endfunction

	// 16-step non-restoring divide on a 56-bit accumulator, quotient word at 47..24
	function automatic longint divide_q23(input longint num, input longint den);
		logic [55:0] acc, dsh;
		logic        carry, neg;
		logic [23:0] word;
		longint      mag;
		mag = (num < 0) ? -num : num;
		acc = 56'(mag) << 24;
		dsh = 56'(den) << 24;
		carry = 1'b0;
		for (int k = 0; k < 16; k++) begin
			neg = acc[55];
			acc = {acc[54:0], carry};
			acc = neg ? acc + dsh : acc - dsh;
			carry = ~acc[55];
		end
		if (num < 0) acc = 56'd0 - acc;
		acc = acc << 32;
		word = acc[47:24];
		return longint'(signed'(word));
	endfunction

	function automatic logic signed [25:0] dsf_sample(input logic md,
			input logic [PBITS-1:0] ph, input logic [22:0] inc);
		longint w, fac, ratio, s, c, num, d60, den, q;
		longint unsigned idx;
		w = (dial_now >= 7'd127) ? 128 : longint'(dial_now);
		fac = 8279556 - 8 * longint'(inc);
		if (fac < 0) fac = 0;
		ratio = w * fac;
		idx = (longint'(ph) * 4 * DEPTH) >> PBITS;
		s = wave_at(idx);
		c = md ? wave_at(2 * idx + DEPTH) : wave_at(idx + DEPTH);
		num = s >>> 4;
		d60 = (longint'(1) << 60) - ratio * c * 256 + ratio * ratio;
		if (d60 < 0) d60 = 0;
		den = d60 >> 39;
		if (den > 8388607) den = 8388607;
		q = divide_q23(num, den);
		return 26'((q * (16384 - 90 * w)) >>> 12);
	endfunction

	// cycle counter and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stall, compare each accepted beat with the oldest prediction
	always @(posedge clk) begin
		logic signed [25:0] want;
		if (arst_n && res_valid && !res_stall) begin
			if (sample_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected sample %0d", sample);
			end else begin
				want = sample_q.pop_front();
				if (sample !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("sample mismatch: expected %0d actual %0d", want, sample);
				end
			end
		end
		res_stall <= !quiet && ($urandom_range(99) < 9);
	end

	// push one beat, predict at the accepting edge
	task automatic send_beat(input logic md, input logic [PBITS-1:0] ph,
			input logic [22:0] inc);
		if (!quiet && $urandom_range(99) < 9) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		src_valid <= 1'b1;
		mode <= md;
		phase <= ph;
		pitch_increment <= inc;
		do @(posedge clk); while (src_stall);
		sample_q.push_back(dsf_sample(md, ph, inc));
	endtask

	task automatic drain;
		src_valid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	// dial written only with the pipe empty
	task automatic write_dial(input logic [6:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dial_now = v;
	endtask

	initial begin
		vec_row_t rows [$];
		logic [22:0] inc;
		logic [6:0]  dial_pick [5];
		for (int k = 0; k <= DEPTH; k++) rom_q23[k] = taylor_q23(k);
		dial_pick = '{7'd0, 7'd127, 7'd126, 7'd64, 7'd1};

		// directed: phase and increment extremes, both modes, ratio floor, near-unit ratio
		rows = '{
			'{7'd0,   1'b0, 24'h000000, 23'h000000},
			'{7'd0,   1'b1, 24'hffffff, 23'h7fffff},
			'{7'd0,   1'b0, 24'h400000, 23'h000001},
			'{7'd127, 1'b0, 24'h000000, 23'h000000},
			'{7'd127, 1'b0, 24'h000400, 23'h000000},
			'{7'd127, 1'b1, 24'h000400, 23'h000000},
			'{7'd127, 1'b0, 24'h400000, 23'h000000},
			'{7'd127, 1'b1, 24'h800000, 23'h000000},
			'{7'd127, 1'b0, 24'hc00000, 23'h000000},
			'{7'd127, 1'b0, 24'hffffff, 23'h7fffff},
			'{7'd127, 1'b0, 24'h001000, 23'd1034944},
			'{7'd127, 1'b1, 24'h001000, 23'd1034945},
			'{7'd127, 1'b0, 24'h100000, 23'h400000},
			'{7'd126, 1'b0, 24'h000800, 23'h000010},
			'{7'd126, 1'b1, 24'h7fffff, 23'h000100},
			'{7'd64,  1'b0, 24'h200000, 23'h001000},
			'{7'd64,  1'b1, 24'h555555, 23'h2aaaaa},
			'{7'd1,   1'b0, 24'haaaaaa, 23'h555555},
			'{7'd1,   1'b1, 24'h3fffff, 23'h0fffff}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].dial != dial_now || i == 0) write_dial(rows[i].dial);
			send_beat(rows[i].md, rows[i].ph, rows[i].inc);
		end

		// random phases, several dial settings; one long stretch without idling
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 300 == 0)
				write_dial((n / 300 < 5) ? dial_pick[n / 300] : 7'($urandom_range(127)));
			quiet = (n >= 600 && n < 900);
			if (n == 1200) drain();
			case ($urandom_range(3))
				0: inc = 23'($urandom_range(4096));
				1: inc = 23'($urandom_range(1034944 + 64, 1034944 - 64));
				default: inc = 23'($urandom);
			endcase
			send_beat(1'($urandom), 24'($urandom), inc);
		end
		quiet = 1'b0;

		src_valid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
